// File: design/kvst_pkg.sv
// Shared types and defaults for the key/value slot table.
package kvst_pkg;

	localparam int KVST_CAPACITY   = 16;
	localparam int KVST_KEY_BITS   = 32;
	localparam int KVST_VALUE_BITS = 64;

	// Operation codes carried on s_tuser; code 3 is a no-op
	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_GET = 2'd1,
		MODE_DEL = 2'd2
	} kvst_mode_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic hit;   // a live matching slot seen upstream
		logic hole;  // a free slot already claimed upstream
	} kvst_link_t;

	// Commit strobes broadcast to every cell
	typedef struct packed {
		logic upd_val; // overwrite value of the hit slot
		logic fill;    // write key/value into the claimed free slot
		logic clear;   // drop the hit slot
	} kvst_cmd_t;

endpackage

// File: design/key_value_slot_table_top.sv
// Top level of the key/value slot table: request control, cell chain and result register.
// After acceptance the request is registered and its search token walks one cell per cycle
// down the chain; the token is captured in ST_SEARCH and the update is committed in
// ST_COMMIT once the result register is free, and only then is a new request taken.
// A finished result may wait in the output register while the next request searches.
// Reset (arst_n low) clears live bits and control at once; keys and values are not
// cleared, no clearing pass is needed.
module key_value_slot_table_top #(
	parameter int CAPACITY   = kvst_pkg::KVST_CAPACITY,
	parameter int KEY_BITS   = kvst_pkg::KVST_KEY_BITS,
	parameter int VALUE_BITS = kvst_pkg::KVST_VALUE_BITS,
	localparam int IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((VALUE_BITS + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // key, value_in, zero pad
	input  logic [1:0]       s_tuser,  // mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // found, full_res, value_out, zero pad
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	state_t                 state_q;
	kvst_pkg::kvst_mode_t   mode_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic                   start_q;
	logic                   hit_q;
	logic                   hole_q;
	logic [VALUE_BITS-1:0]  get_val_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic                   full_q;
	logic [VALUE_BITS-1:0]  vout_q;

	logic                   in_take;
	logic                   out_free;
	logic                   commit_go;
	logic                   is_set;
	logic                   is_get;
	logic                   is_del;
	kvst_pkg::kvst_cmd_t    cmd;

	kvst_pkg::kvst_link_t   link [0:CAPACITY];
	logic [VALUE_BITS-1:0]  val_chain [0:CAPACITY];
	logic [CAPACITY-1:0]    hit_marks;
	logic [CAPACITY-1:0]    hole_marks;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign commit_go = (state_q == ST_COMMIT) && out_free;

	// decode of the held request
	always_comb begin
		is_set = 1'b0;
		is_get = 1'b0;
		is_del = 1'b0;
		unique case (mode_q)
			kvst_pkg::MODE_SET: is_set = 1'b1;
			kvst_pkg::MODE_GET: is_get = 1'b1;
			kvst_pkg::MODE_DEL: is_del = 1'b1;
			default: ;  // no-op code
		endcase
	end

	// commit strobes: hit slot overwritten/dropped, else first free slot filled
	assign cmd.upd_val = commit_go && is_set && hit_q;
	assign cmd.fill    = commit_go && is_set && !hit_q && hole_q;
	assign cmd.clear   = commit_go && is_del && hit_q;

	// token enters the chain in the cycle after acceptance, when key_q is settled
	assign link[0].valid = start_q;
	assign link[0].hit   = 1'b0;
	assign link[0].hole  = 1'b0;
	assign val_chain[0]  = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kvst_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_key   (key_q),
			.wr_value (value_q),
			.cmd      (cmd),
			.link_in  (link[i]),
			.val_in   (val_chain[i]),
			.link_out (link[i+1]),
			.val_out  (val_chain[i+1]),
			.hit_mark (hit_marks[i]),
			.hole_mark(hole_marks[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= kvst_pkg::MODE_SET;
			key_q       <= '0;
			value_q     <= '0;
			hit_q       <= 1'b0;
			hole_q      <= 1'b0;
			get_val_q   <= '0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
			vout_q      <= '0;
		end else begin
			start_q <= in_take;
			// result register: loaded on commit, emptied when taken
			if (commit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						mode_q  <= kvst_pkg::kvst_mode_t'(s_tuser);
						key_q   <= s_tdata[KEY_BITS-1:0];
						value_q <= s_tdata[KEY_BITS +: VALUE_BITS];
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (link[CAPACITY].valid) begin
						hit_q     <= link[CAPACITY].hit;
						hole_q    <= link[CAPACITY].hole;
						get_val_q <= val_chain[CAPACITY];
						state_q   <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						found_q     <= (is_set || is_get || is_del) && hit_q;
						full_q      <= is_set && !hit_q && !hole_q;
						vout_q      <= (is_get && hit_q) ? get_val_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - VALUE_BITS - 2){1'b0}}, vout_q, full_q, found_q};

	// keys stay unique among live slots, so at most one cell can claim a hit;
	// marks are only all from the same search once the token has left the chain
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> $onehot0(hit_marks))
		else $error("more than one slot matched the key");

	a_one_hole: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> $onehot0(hole_marks))
		else $error("more than one free slot claimed");

	// a commit never overruns a result still waiting downstream
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd_val || cmd.fill || cmd.clear) |-> out_free)
		else $error("commit while result register blocked");

	// the chain is empty whenever a new request may be taken
	a_chain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !link[CAPACITY].valid)
		else $error("search token still in flight at request acceptance");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("full reported together with found");

endmodule

// File: design/kvst_cell.sv
// One slot of the table: key, value and live bit, plus one stage of the search chain.
module kvst_cell #(
	parameter int KEY_BITS   = kvst_pkg::KVST_KEY_BITS,
	parameter int VALUE_BITS = kvst_pkg::KVST_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  kvst_pkg::kvst_cmd_t   cmd,
	input  kvst_pkg::kvst_link_t  link_in,
	input  logic [VALUE_BITS-1:0] val_in,
	output kvst_pkg::kvst_link_t  link_out,
	output logic [VALUE_BITS-1:0] val_out,
	output logic                  hit_mark,
	output logic                  hole_mark
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  live_q;
	logic                  hit_mark_q;
	logic                  hole_mark_q;
	kvst_pkg::kvst_link_t  link_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic                  match;
	logic                  free;

	assign match = live_q && (key_q == wr_key);
	assign free  = !live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= 1'b0;
			hit_mark_q  <= 1'b0;
			hole_mark_q <= 1'b0;
			link_s1     <= '0;
		end else begin
			link_s1.valid <= link_in.valid;
			link_s1.hit   <= link_in.hit  | (link_in.valid & match);
			link_s1.hole  <= link_in.hole | (link_in.valid & free);
			if (link_in.valid) begin
				hit_mark_q  <= match;
				hole_mark_q <= free && !link_in.hole;
			end
			if (cmd.fill && hole_mark_q) begin
				live_q <= 1'b1;
			end else if (cmd.clear && hit_mark_q) begin
				live_q <= 1'b0;
			end
		end
	end

	// slot payload and travelling read value, no reset
	always_ff @(posedge clk) begin
		val_s1 <= (link_in.valid && match) ? val_q : val_in;
		if (cmd.fill && hole_mark_q) begin
			key_q <= wr_key;
			val_q <= wr_value;
		end else if (cmd.upd_val && hit_mark_q) begin
			val_q <= wr_value;
		end
	end

	assign link_out  = link_s1;
	assign val_out   = val_s1;
	assign hit_mark  = hit_mark_q;
	assign hole_mark = hole_mark_q;

endmodule
